/* rtl/mtg_pkg.sv */
// Package for the MT19937 generator: sizes, constants, command and state codes.
// Used by every module of the block.
`default_nettype none
package mtg_pkg;
   localparam int STATE_DEPTH   = 624;
   localparam int STATE_AW      = 10;
   localparam int MAX_KEY_WORDS = 16;
   localparam int SHIFT_OFFSET  = 397;

   localparam logic [31:0] MATRIX_A    = 32'h9908B0DF;
   localparam logic [31:0] UPPER_BIT   = 32'h80000000;
   localparam logic [31:0] SEED_MULT   = 32'd1812433253;
   localparam logic [31:0] MIX1_MULT   = 32'd1664525;
   localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
   localparam logic [31:0] ARRAY_SEED  = 32'd19650218;
   localparam logic [31:0] DFLT_SEED   = 32'd5489;
   localparam logic [31:0] TEMPER_B    = 32'h9D2C5680;
   localparam logic [31:0] TEMPER_C    = 32'hEFC60000;
   localparam logic [STATE_AW-1:0] IDX_FULL     = STATE_AW'(STATE_DEPTH);
   localparam logic [STATE_AW-1:0] IDX_UNSEEDED = STATE_AW'(STATE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_DRAW = 2'd0,
      CMD_SEED = 2'd1,
      CMD_KEY  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MUL_SEED,
      MUL_MIX1,
      MUL_MIX2
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_BEGIN,
      ST_SEED_MUL,
      ST_SEED_WR,
      ST_A1_MUL,
      ST_A1_WR,
      ST_A1_WRAP,
      ST_A2_MUL,
      ST_A2_WR,
      ST_A2_WRAP,
      ST_A_TOP,
      ST_RG_PRE,
      ST_RG_LD,
      ST_RG_A,
      ST_RG_B,
      ST_DR_RD
   } state_type;

   typedef struct packed {
      logic                en;
      logic [STATE_AW-1:0] addr;
      logic [31:0]         data;
   } ram_wr_type;
endpackage
`default_nettype wire

/* rtl/mtg_state_ram.sv */
// State word memory: one write port, two registered read ports.
// Depends on mtg_pkg.
`default_nettype none
module mtg_state_ram #(
   parameter int DEPTH = mtg_pkg::STATE_DEPTH
) (
   input  wire                                clock,
   input  wire mtg_pkg::ram_wr_type           wr,
   input  wire logic [mtg_pkg::STATE_AW-1:0]  rd1_addr,
   input  wire logic [mtg_pkg::STATE_AW-1:0]  rd2_addr,
   output logic [31:0]                        rd1_data_ff,
   output logic [31:0]                        rd2_data_ff
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd1_data_ff <= mem[rd1_addr];
      rd2_data_ff <= mem[rd2_addr];
   end
endmodule
`default_nettype wire

/* rtl/mtg_mix_unit.sv */
// Shared multiplier: registers (p ^ (p >> 30)) * K for the selected constant.
// Depends on mtg_pkg.
`default_nettype none
module mtg_mix_unit (
   input  wire                       clock,
   input  wire logic [31:0]          operand,
   input  wire mtg_pkg::mul_sel_type sel,
   output logic [31:0]               prod_ff
);
   logic [31:0] x;
   logic [31:0] k;
   logic [63:0] full;
   logic [31:0] prod_in;

   always_comb begin
      x = operand ^ (operand >> 30);
      unique case (sel)
         mtg_pkg::MUL_SEED: k = mtg_pkg::SEED_MULT;
         mtg_pkg::MUL_MIX1: k = mtg_pkg::MIX1_MULT;
         mtg_pkg::MUL_MIX2: k = mtg_pkg::MIX2_MULT;
         default:           k = mtg_pkg::SEED_MULT;
      endcase
      full    = {32'd0, x} * {32'd0, k};
      prod_in = full[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

/* rtl/mersenne_twister_generator.sv */
// MT19937 generator top: sequencer, key buffer, tempering and result valid register.
// Draws read their word in DR_RD, tempered from the RAM read register. A draw on a full
// state regenerates first; an unseeded one seeds first. A last key runs array init.
// One item at a time: busy stays high until the item's work is done; a result is
// shown for one cycle and cannot stall. State words go one at a time through the
// single RAM write port, with the shared multiplier for seeding and array init.
// Reset (synchronous) marks the generator unseeded and empties the key buffer.
`default_nettype none
module mersenne_twister_generator #(
   parameter int MAX_KEY_WORDS = mtg_pkg::MAX_KEY_WORDS
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  wire  [1:0]   req_cmd,
   input  wire  [31:0]  req_data,
   input  wire          req_last_key,
   output logic         rsp_valid,
   output logic [31:0]  rsp_number
);
   localparam int KW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
   localparam int CW = $clog2(MAX_KEY_WORDS + 1);
   localparam int AW = mtg_pkg::STATE_AW;
   localparam logic [AW-1:0] LAST_W = AW'(mtg_pkg::STATE_DEPTH - 1);
   localparam logic [CW-1:0] KMAX   = CW'(MAX_KEY_WORDS);

   mtg_pkg::state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] n_ff, n_in;
   logic [AW-1:0] k_ff, k_in;
   logic [KW-1:0] j_ff, j_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   seed_ff, seed_in;
   logic          pend_draw_ff, pend_draw_in;
   logic          pend_arr_ff, pend_arr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [31:0]   key_mem [MAX_KEY_WORDS];
   logic [31:0]   key_rd_ff;
   logic          key_we;

   mtg_pkg::ram_wr_type  wr;
   mtg_pkg::mul_sel_type mul_sel;
   logic [AW-1:0] rd1_addr, rd2_addr;
   logic [31:0]   rd1_data_ff, rd2_data_ff, prod_ff;
   logic [AW-1:0] nx, far_addr;
   logic [AW:0]   far_sum;
   logic [CW-1:0] cnt_after;
   logic [31:0]   new_word, y, t;
   logic [KW:0]   j_inc;
   logic          accept;

   mtg_state_ram #(.DEPTH(mtg_pkg::STATE_DEPTH)) u_ram (
      .clock(clock), .wr(wr), .rd1_addr(rd1_addr), .rd2_addr(rd2_addr),
      .rd1_data_ff(rd1_data_ff), .rd2_data_ff(rd2_data_ff)
   );

   mtg_mix_unit u_mix (
      .clock(clock), .operand(prev_ff), .sel(mul_sel), .prod_ff(prod_ff)
   );

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[cnt_ff[KW-1:0]] <= req_data;
      end
      key_rd_ff <= key_mem[j_ff];
   end

   assign accept = start && (state_ff == mtg_pkg::ST_IDLE);
   assign busy   = (state_ff != mtg_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      seed_in       = seed_ff;
      pend_draw_in  = pend_draw_ff;
      pend_arr_in   = pend_arr_ff;
      rsp_valid_in  = 1'b0;
      key_we        = 1'b0;
      wr            = '0;
      mul_sel       = mtg_pkg::MUL_SEED;
      rd1_addr      = n_ff;
      rd2_addr      = '0;
      new_word      = '0;
      y             = '0;
      t             = '0;
      nx            = (n_ff == LAST_W) ? '0 : n_ff + 1'b1;
      far_sum       = {1'b0, n_ff} + (AW+1)'(mtg_pkg::SHIFT_OFFSET);
      far_addr      = (far_sum >= (AW+1)'(mtg_pkg::STATE_DEPTH))
                      ? AW'(far_sum - (AW+1)'(mtg_pkg::STATE_DEPTH)) : far_sum[AW-1:0];
      cnt_after     = (cnt_ff < KMAX) ? cnt_ff + 1'b1 : cnt_ff;
      j_inc         = {1'b0, j_ff} + 1'b1;

      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (accept) begin
               pend_draw_in = 1'b0;
               pend_arr_in  = 1'b0;
               priority case (mtg_pkg::cmd_type'(req_cmd))
                  mtg_pkg::CMD_DRAW: begin
                     if (idx_ff == mtg_pkg::IDX_UNSEEDED) begin
                        seed_in      = mtg_pkg::DFLT_SEED;
                        pend_draw_in = 1'b1;
                        state_in     = mtg_pkg::ST_SEED_BEGIN;
                     end else if (idx_ff == mtg_pkg::IDX_FULL) begin
                        state_in = mtg_pkg::ST_RG_PRE;
                     end else begin
                        state_in = mtg_pkg::ST_DR_RD;
                     end
                  end
                  mtg_pkg::CMD_SEED: begin
                     seed_in  = req_data;
                     state_in = mtg_pkg::ST_SEED_BEGIN;
                  end
                  mtg_pkg::CMD_KEY: begin
                     key_we = (cnt_ff < KMAX);
                     cnt_in = cnt_after;
                     if (req_last_key) begin
                        seed_in     = mtg_pkg::ARRAY_SEED;
                        pend_arr_in = 1'b1;
                        len_in      = (cnt_after == '0) ? CW'(1) : cnt_after;
                        cnt_in      = '0;
                        state_in    = mtg_pkg::ST_SEED_BEGIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mtg_pkg::ST_SEED_BEGIN: begin
            wr       = '{en: 1'b1, addr: '0, data: seed_ff};
            prev_in  = seed_ff;
            n_in     = AW'(1);
            state_in = mtg_pkg::ST_SEED_MUL;
         end
         mtg_pkg::ST_SEED_MUL: begin
            mul_sel  = mtg_pkg::MUL_SEED;
            state_in = mtg_pkg::ST_SEED_WR;
         end
         mtg_pkg::ST_SEED_WR: begin
            new_word = prod_ff + 32'(n_ff);
            wr       = '{en: 1'b1, addr: n_ff, data: new_word};
            prev_in  = new_word;
            n_in     = n_ff + 1'b1;
            state_in = mtg_pkg::ST_SEED_MUL;
            if (n_ff == LAST_W) begin
               idx_in = mtg_pkg::IDX_FULL;
               if (pend_arr_ff) begin
                  prev_in     = mtg_pkg::ARRAY_SEED;
                  n_in        = AW'(1);
                  j_in        = '0;
                  k_in        = AW'(mtg_pkg::STATE_DEPTH);
                  pend_arr_in = 1'b0;
                  state_in    = mtg_pkg::ST_A1_MUL;
               end else if (pend_draw_ff) begin
                  pend_draw_in = 1'b0;
                  state_in     = mtg_pkg::ST_RG_PRE;
               end else begin
                  state_in = mtg_pkg::ST_IDLE;
               end
            end
         end
         mtg_pkg::ST_A1_MUL: begin
            mul_sel  = mtg_pkg::MUL_MIX1;
            rd1_addr = n_ff;
            state_in = mtg_pkg::ST_A1_WR;
         end
         mtg_pkg::ST_A1_WR: begin
            new_word = (rd1_data_ff ^ prod_ff) + key_rd_ff + 32'(j_ff);
            wr       = '{en: 1'b1, addr: n_ff, data: new_word};
            prev_in  = new_word;
            j_in     = (j_inc >= (KW+1)'(len_ff)) ? '0 : j_inc[KW-1:0];
            k_in     = k_ff - 1'b1;
            if (n_ff == LAST_W) begin
               n_in     = AW'(1);
               state_in = mtg_pkg::ST_A1_WRAP;
            end else begin
               n_in = n_ff + 1'b1;
               if (k_ff == AW'(1)) begin
                  k_in     = LAST_W;
                  state_in = mtg_pkg::ST_A2_MUL;
               end else begin
                  state_in = mtg_pkg::ST_A1_MUL;
               end
            end
         end
         mtg_pkg::ST_A1_WRAP: begin
            wr = '{en: 1'b1, addr: '0, data: prev_ff};
            if (k_ff == '0) begin
               k_in     = LAST_W;
               state_in = mtg_pkg::ST_A2_MUL;
            end else begin
               state_in = mtg_pkg::ST_A1_MUL;
            end
         end
         mtg_pkg::ST_A2_MUL: begin
            mul_sel  = mtg_pkg::MUL_MIX2;
            rd1_addr = n_ff;
            state_in = mtg_pkg::ST_A2_WR;
         end
         mtg_pkg::ST_A2_WR: begin
            new_word = (rd1_data_ff ^ prod_ff) - 32'(n_ff);
            wr       = '{en: 1'b1, addr: n_ff, data: new_word};
            prev_in  = new_word;
            k_in     = k_ff - 1'b1;
            if (n_ff == LAST_W) begin
               n_in     = AW'(1);
               state_in = mtg_pkg::ST_A2_WRAP;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = (k_ff == AW'(1)) ? mtg_pkg::ST_A_TOP : mtg_pkg::ST_A2_MUL;
            end
         end
         mtg_pkg::ST_A2_WRAP: begin
            wr       = '{en: 1'b1, addr: '0, data: prev_ff};
            state_in = (k_ff == '0) ? mtg_pkg::ST_A_TOP : mtg_pkg::ST_A2_MUL;
         end
         mtg_pkg::ST_A_TOP: begin
            wr       = '{en: 1'b1, addr: '0, data: mtg_pkg::UPPER_BIT};
            idx_in   = mtg_pkg::IDX_FULL;
            state_in = mtg_pkg::ST_IDLE;
         end
         mtg_pkg::ST_RG_PRE: begin
            rd1_addr = '0;
            n_in     = '0;
            state_in = mtg_pkg::ST_RG_LD;
         end
         mtg_pkg::ST_RG_LD: begin
            cur_in   = rd1_data_ff;
            state_in = mtg_pkg::ST_RG_A;
         end
         mtg_pkg::ST_RG_A: begin
            rd1_addr = nx;
            rd2_addr = far_addr;
            state_in = mtg_pkg::ST_RG_B;
         end
         mtg_pkg::ST_RG_B: begin
            y        = {cur_ff[31], rd1_data_ff[30:0]};
            new_word = rd2_data_ff ^ (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_A : 32'd0);
            wr       = '{en: 1'b1, addr: n_ff, data: new_word};
            cur_in   = rd1_data_ff;
            n_in     = n_ff + 1'b1;
            state_in = mtg_pkg::ST_RG_A;
            if (n_ff == LAST_W) begin
               idx_in   = '0;
               state_in = mtg_pkg::ST_DR_RD;
            end
         end
         mtg_pkg::ST_DR_RD: begin
            rd1_addr = idx_ff;
            state_in = mtg_pkg::ST_IDLE;
            // data returns next cycle and is tempered straight from the read register
            rsp_valid_in = 1'b1;
            idx_in       = idx_ff + 1'b1;
         end
         default: state_in = mtg_pkg::ST_IDLE;
      endcase

      t = rd1_data_ff;
      t = t ^ (t >> 11);
      t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
      t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
      t = t ^ (t >> 18);
   end

   // The draw read is issued in DR_RD; the word is tempered as it leaves the RAM.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::ST_IDLE;
         idx_ff       <= mtg_pkg::IDX_UNSEEDED;
         cnt_ff       <= '0;
         pend_draw_ff <= 1'b0;
         pend_arr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_draw_ff <= pend_draw_in;
         pend_arr_ff  <= pend_arr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      len_ff        <= len_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      seed_ff       <= seed_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_number = t;

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == mtg_pkg::ST_DR_RD)
      else $error("result without draw read");
   a_draw_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == mtg_pkg::ST_DR_RD |-> idx_ff < mtg_pkg::IDX_FULL)
      else $error("draw index out of range");
   a_key_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= KMAX)
      else $error("key count overflow");
   a_key_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == mtg_pkg::ST_A1_MUL |-> (KW+1)'(j_ff) < (KW+1)'(len_ff))
      else $error("key index beyond length");
endmodule
`default_nettype wire

/* sim/mersenne_twister_generator_checker.sv */
// Scoreboard for the MT19937 generator: watches the command and result channels,
// keeps its own copy of the generator state and compares every drawn number.
// Depends on mtg_pkg for sizes, constants and command codes.
module mersenne_twister_generator_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  wire  [1:0]  req_cmd,
   input  wire  [31:0] req_data,
   input  wire         req_last_key,
   input  wire         rsp_valid,
   input  wire  [31:0] rsp_number,
   output int          errors,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] mt_words [mtg_pkg::STATE_DEPTH];
   int          mt_index;
   logic [31:0] key_words [mtg_pkg::MAX_KEY_WORDS];
   int          key_fill;
   logic [31:0] expected_numbers [$];

   assign pending = expected_numbers.size();

   function automatic logic [31:0] mix_prev(logic [31:0] p);
      return p ^ (p >> 30);
   endfunction

   task automatic seed_words(logic [31:0] s);
      mt_words[0] = s;
      for (int n = 1; n < mtg_pkg::STATE_DEPTH; n++)
         mt_words[n] = mtg_pkg::SEED_MULT * mix_prev(mt_words[n-1]) + 32'(n);
      mt_index = mtg_pkg::STATE_DEPTH;
   endtask

   task automatic seed_from_keys(int len);
      int i;
      int j;
      i = 1;
      j = 0;
      seed_words(mtg_pkg::ARRAY_SEED);
      if (len == 0) len = 1;
      if (len > mtg_pkg::MAX_KEY_WORDS) len = mtg_pkg::MAX_KEY_WORDS;
      for (int k = (mtg_pkg::STATE_DEPTH > len) ? mtg_pkg::STATE_DEPTH : len; k != 0;
           k--) begin
         mt_words[i] = (mt_words[i] ^ (mix_prev(mt_words[i-1]) * mtg_pkg::MIX1_MULT))
                       + key_words[j] + 32'(j);
         i++;
         j++;
         if (i >= mtg_pkg::STATE_DEPTH) begin
            mt_words[0] = mt_words[mtg_pkg::STATE_DEPTH-1];
            i = 1;
         end
         if (j >= len) j = 0;
      end
      for (int k = mtg_pkg::STATE_DEPTH - 1; k != 0; k--) begin
         mt_words[i] = (mt_words[i] ^ (mix_prev(mt_words[i-1]) * mtg_pkg::MIX2_MULT))
                       - 32'(i);
         i++;
         if (i >= mtg_pkg::STATE_DEPTH) begin
            mt_words[0] = mt_words[mtg_pkg::STATE_DEPTH-1];
            i = 1;
         end
      end
      mt_words[0] = mtg_pkg::UPPER_BIT;
      mt_index = mtg_pkg::STATE_DEPTH;
   endtask

   task automatic twist_state();
      logic [31:0] y;
      for (int n = 0; n < mtg_pkg::STATE_DEPTH; n++) begin
         y = (mt_words[n] & mtg_pkg::UPPER_BIT)
             | (mt_words[(n+1) % mtg_pkg::STATE_DEPTH] & ~mtg_pkg::UPPER_BIT);
         mt_words[n] = mt_words[(n+mtg_pkg::SHIFT_OFFSET) % mtg_pkg::STATE_DEPTH]
                       ^ (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_A : 32'h0);
      end
      mt_index = 0;
   endtask

   task automatic predict_number();
      logic [31:0] y;
      if (mt_index >= mtg_pkg::STATE_DEPTH) begin
         if (mt_index != mtg_pkg::STATE_DEPTH) seed_words(mtg_pkg::DFLT_SEED);
         twist_state();
      end
      y = mt_words[mt_index];
      mt_index++;
      y ^= y >> 11;
      y ^= (y << 7) & mtg_pkg::TEMPER_B;
      y ^= (y << 15) & mtg_pkg::TEMPER_C;
      y ^= y >> 18;
      expected_numbers.push_back(y);
   endtask

   task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= 10)
         $display("%0t mismatch: %s expected %08h actual %08h", $time, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mt_index = mtg_pkg::STATE_DEPTH + 1;
         key_fill = 0;
         errors = 0;
         checked = 0;
         expected_numbers.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_numbers.size() == 0) begin
               report("unexpected number", 32'h0, rsp_number);
            end else begin
               logic [31:0] exp_v;
               exp_v = expected_numbers.pop_front();
               checked++;
               if (rsp_number !== exp_v) report("number", exp_v, rsp_number);
            end
         end
         if (start && !busy) begin
            unique case (mtg_pkg::cmd_type'(req_cmd))
               mtg_pkg::CMD_DRAW: predict_number();
               mtg_pkg::CMD_SEED: seed_words(req_data);
               mtg_pkg::CMD_KEY: begin
                  if (key_fill < mtg_pkg::MAX_KEY_WORDS) begin
                     key_words[key_fill] = req_data;
                     key_fill++;
                  end
                  if (req_last_key) begin
                     seed_from_keys(key_fill);
                     key_fill = 0;
                  end
               end
               default: ;
            endcase
         end
      end
   end
endmodule

/* sim/mersenne_twister_generator_tb.sv */
// Testbench top for the MT19937 generator: clock, reset, command stimulus with
// random gaps, watchdog and verdict. Needs mtg_pkg, the RTL and the checker.
module mersenne_twister_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_data;
   logic        req_last_key;
   logic        rsp_valid;
   logic [31:0] rsp_number;
   int          errors;
   int          pending;
   int          checked;
   int          sent_items;
   int          sent_draws;
   int          sent_keys;
   int          idle_cycles;

   mersenne_twister_generator u_top (
      .clock, .reset, .start, .busy, .req_cmd, .req_data, .req_last_key,
      .rsp_valid, .rsp_number
   );

   mersenne_twister_generator_checker u_checker (
      .clock, .reset, .start, .busy, .req_cmd, .req_data, .req_last_key,
      .rsp_valid, .rsp_number, .errors, .pending, .checked
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[mersenne_twister_generator] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send(mtg_pkg::cmd_type cmd, logic [31:0] data, logic last);
      int gap;
      req_cmd <= cmd;
      req_data <= data;
      req_last_key <= last;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sent_items++;
      if (cmd == mtg_pkg::CMD_DRAW) sent_draws++;
      if (cmd == mtg_pkg::CMD_KEY) sent_keys++;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: gap = 0;
         9:          gap = $urandom_range(20, 60);
         default:    gap = $urandom_range(1, 3);
      endcase
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic key_burst(int n);
      for (int k = 1; k <= n; k++)
         send(mtg_pkg::CMD_KEY, $urandom, k == n);
   endtask

   initial begin
      int pick;
      bit drained;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = mtg_pkg::CMD_DRAW;
      req_data = '0;
      req_last_key = 1'b0;
      sent_items = 0;
      sent_draws = 0;
      sent_keys = 0;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default seed, seed extremes, single and overflowing keys, odd commands
      send(mtg_pkg::CMD_DRAW, 32'hFFFFFFFF, 1'b1);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_SEED, 32'h0, 1'b1);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_SEED, 32'hFFFFFFFF, 1'b0);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_KEY, 32'hFFFFFFFF, 1'b1);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_NONE, 32'hA5A5A5A5, 1'b1);
      send(mtg_pkg::CMD_NONE, 32'h5A5A5A5A, 1'b0);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_KEY, 32'h00000123, 1'b0);
      send(mtg_pkg::CMD_SEED, 32'd5489, 1'b0);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      send(mtg_pkg::CMD_KEY, 32'h00000000, 1'b1);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
      key_burst(mtg_pkg::MAX_KEY_WORDS + 2);
      send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);

      while (sent_items < 2000) begin
         if (!drained && sent_items >= 1000) begin
            drained = 1'b1;
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 86)      send(mtg_pkg::CMD_DRAW, $urandom, 1'($urandom));
         else if (pick < 89) send(mtg_pkg::CMD_SEED, $urandom, 1'($urandom));
         else if (pick < 92) key_burst($urandom_range(1, 4));
         else if (pick < 93) key_burst($urandom_range(mtg_pkg::MAX_KEY_WORDS - 1,
                                                      mtg_pkg::MAX_KEY_WORDS + 4));
         else if (pick < 96) send(mtg_pkg::CMD_KEY, $urandom, 1'b0);
         else                send(mtg_pkg::CMD_NONE, $urandom, 1'($urandom));
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d items (%0d draws, %0d key words); %0d numbers checked.",
               sent_items, sent_draws, sent_keys, checked);
      if (errors == 0 && pending == 0) begin
         $display("[mersenne_twister_generator] OK");
      end else begin
         $display("[mersenne_twister_generator] ERROR");
      end
      $finish;
   end
endmodule
